// ===== hw/rtl/sabr_pkg.sv =====
`timescale 1ns / 1ps

package sabr_pkg;

    // Sample and result widths are fixed by the sensor format.
    localparam int SAMPLE_BITS       = 24;
    localparam int COMP_BITS         = SAMPLE_BITS + 1;
    localparam int NUM_CH            = 6;
    localparam int AVG_COUNT_DEFAULT = 100;

    // Stream widths: tdata is packed channel by channel and padded to whole bytes.
    localparam int IN_DATA_W  = NUM_CH * SAMPLE_BITS;
    localparam int OUT_DATA_W = ((NUM_CH * COMP_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // Bit positions in the result tuser.
    localparam int USER_ESTIMATING = 0;
    localparam int USER_DONE       = 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_Z = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COMP_BITS-1:0]   comp_t;

endpackage

// ===== hw/rtl/six_axis_bias_estimate_and_removal_top.sv =====
`timescale 1ns / 1ps

// A result passes five register stages: input, sums, magnitudes, quotients, output.
// Throughput: one sample per cycle unless m_tready stalls the result stream; the accumulate,
// magnitude, reciprocal multiply and subtract stages are registered, so samples overlap.
// Reset (rst_n low, asynchronous): pipeline empty, no estimate running, learned bias
// invalid, configured offsets zero. No clearing pass is needed after reset.
module six_axis_bias_estimate_and_removal_top
    import sabr_pkg::*;
#(
    parameter int AVG_COUNT = AVG_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z (24 bits each)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // start_estimate
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // comp_force_x, comp_force_y, comp_force_z, comp_torque_x, comp_torque_y,
    // comp_torque_z (25 bits each), zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // estimating, estimate_done
    output logic [OUT_USER_W-1:0] m_tuser,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data
);

    // Derived sizes: the running sum of AVG_COUNT samples is held exactly.
    localparam int CNT_W     = $clog2(AVG_COUNT + 1);
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_SHIFT = MAG_W + $clog2(AVG_COUNT);
    localparam int RECIP_W   = MAG_W + 2;
    localparam int PROD_W    = MAG_W + RECIP_W;
    // Rounded-up reciprocal: floor(x / AVG_COUNT) == (x * RECIP) >> DIV_SHIFT for x < 2^MAG_W.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVG_COUNT);

    // Handshake chain
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, out_valid_reg;
    logic p1_ready, p2_ready, p3_ready, p4_ready, out_ready;
    logic p1_adv, p4_adv;

    // Estimation state
    logic signed [SUM_W-1:0] sum_reg [NUM_CH];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    sample_t                 cfg_bias_reg [NUM_CH];
    sample_t                 learned_reg [NUM_CH];
    logic                    learned_valid_reg;

    // Stage 1: input register
    logic    p1_start_reg;
    sample_t p1_smp_reg [NUM_CH];

    // Stage 2: updated sums
    sample_t                 p2_smp_reg [NUM_CH];
    logic signed [SUM_W-1:0] p2_sum_reg [NUM_CH];
    logic                    p2_done_reg, p2_est_reg;

    // Stage 3: sum magnitudes
    sample_t          p3_smp_reg [NUM_CH];
    logic [MAG_W-1:0] p3_mag_reg [NUM_CH];
    logic [NUM_CH-1:0] p3_neg_reg;
    logic             p3_done_reg, p3_est_reg;

    // Stage 4: quotient magnitudes
    sample_t                p4_smp_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] p4_quot_reg [NUM_CH];
    logic [NUM_CH-1:0]      p4_neg_reg;
    logic                   p4_done_reg, p4_est_reg;

    // Output register
    comp_t comp_reg [NUM_CH];
    logic  out_est_reg, out_done_reg;

    // Combinational results
    logic                    start_hit, acc_en, done_c, est_c;
    logic [CNT_W-1:0]        cnt_next;
    logic signed [SUM_W-1:0] sum_next [NUM_CH];
    logic [MAG_W-1:0]        mag_c [NUM_CH];
    logic [PROD_W-1:0]       prod_c [NUM_CH];
    sample_t                 fresh_bias [NUM_CH];
    comp_t                   comp_next [NUM_CH];

    // Ready propagates back through the stages; a bubble lets its predecessor move.
    assign out_ready = !out_valid_reg || m_tready;
    assign p4_ready  = !p4_valid_reg || out_ready;
    assign p3_ready  = !p3_valid_reg || p4_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_tready  = p1_ready;
    assign p1_adv    = p1_valid_reg && p2_ready;
    assign p4_adv    = p4_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
            begin
                p1_valid_reg <= s_tvalid;
            end
            if (p2_ready)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (p4_ready)
            begin
                p4_valid_reg <= p3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= p4_valid_reg;
            end
        end
    end

    // Accumulation: a start request while idle clears the sums and counts this sample first.
    always_comb
    begin
        start_hit = p1_start_reg && !busy_reg;
        acc_en    = busy_reg || start_hit;
        cnt_next  = (start_hit ? '0 : cnt_reg) + CNT_W'(1);
        done_c    = acc_en && (cnt_next == CNT_LAST);
        est_c     = acc_en && !done_c;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_next[ch] = (start_hit ? '0 : sum_reg[ch]) + SUM_W'(p1_smp_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                sum_reg[ch] <= '0;
            end
        end
        else if (p1_adv && acc_en)
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= !done_c;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    // Magnitude of each sum, then the reciprocal multiply.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            mag_c[ch]  = MAG_W'(p2_sum_reg[ch][SUM_W-1] ? -p2_sum_reg[ch] : p2_sum_reg[ch]);
            prod_c[ch] = PROD_W'(p3_mag_reg[ch]) * PROD_W'(RECIP);
        end
    end

    // Final stage: a completing item uses its fresh mean, others learned or configured bias.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            logic signed [COMP_BITS-1:0] smp_ext;
            logic signed [COMP_BITS-1:0] quot_ext;
            sample_t                     old_bias;
            smp_ext        = COMP_BITS'(p4_smp_reg[ch]);
            quot_ext       = {1'b0, p4_quot_reg[ch]};
            old_bias       = learned_valid_reg ? learned_reg[ch] : cfg_bias_reg[ch];
            fresh_bias[ch] = p4_neg_reg[ch] ? sample_t'(-p4_quot_reg[ch])
                                            : sample_t'(p4_quot_reg[ch]);
            if (p4_done_reg)
            begin
                comp_next[ch] = p4_neg_reg[ch] ? smp_ext + quot_ext : smp_ext - quot_ext;
            end
            else
            begin
                comp_next[ch] = smp_ext - COMP_BITS'(old_bias);
            end
        end
    end

    // Offsets and learned bias; a mapped write reloads an offset and voids the learned bias.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learned_valid_reg <= 1'b0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                cfg_bias_reg[ch] <= '0;
                learned_reg[ch]  <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index <= REG_BIAS_TORQUE_Z)
            begin
                cfg_bias_reg[cfg_index] <= cfg_data;
                learned_valid_reg       <= 1'b0;
            end
        end
        else if (p4_adv && p4_done_reg)
        begin
            learned_valid_reg <= 1'b1;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                learned_reg[ch] <= fresh_bias[ch];
            end
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && p1_ready)
        begin
            p1_start_reg <= s_tuser;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                p1_smp_reg[ch] <= s_tdata[ch*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        if (p1_valid_reg && p2_ready)
        begin
            p2_done_reg <= done_c;
            p2_est_reg  <= est_c;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                p2_smp_reg[ch] <= p1_smp_reg[ch];
                p2_sum_reg[ch] <= sum_next[ch];
            end
        end
        if (p2_valid_reg && p3_ready)
        begin
            p3_done_reg <= p2_done_reg;
            p3_est_reg  <= p2_est_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                p3_smp_reg[ch] <= p2_smp_reg[ch];
                p3_mag_reg[ch] <= mag_c[ch];
                p3_neg_reg[ch] <= p2_sum_reg[ch][SUM_W-1];
            end
        end
        if (p3_valid_reg && p4_ready)
        begin
            p4_done_reg <= p3_done_reg;
            p4_est_reg  <= p3_est_reg;
            p4_neg_reg  <= p3_neg_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                p4_smp_reg[ch]  <= p3_smp_reg[ch];
                p4_quot_reg[ch] <= prod_c[ch][DIV_SHIFT +: SAMPLE_BITS];
            end
        end
        if (p4_adv)
        begin
            out_done_reg <= p4_done_reg;
            out_est_reg  <= p4_est_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                comp_reg[ch] <= comp_next[ch];
            end
        end
    end

    // Result stream packing
    always_comb
    begin
        m_tdata = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            m_tdata[ch*COMP_BITS +: COMP_BITS] = comp_reg[ch];
        end
        m_tuser                  = '0;
        m_tuser[USER_ESTIMATING] = out_est_reg;
        m_tuser[USER_DONE]       = out_done_reg;
    end

    assign m_tvalid = out_valid_reg;

    // A finished estimate never reports itself as still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && p2_done_reg) |-> !p2_est_reg)
        else $error("estimate done and still estimating on the same item");

    // The sample count never reaches the average length while an estimate runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < CNT_LAST))
        else $error("sample count overran while estimating");

    // The learned bias becomes valid only when a completing item leaves the last stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(learned_valid_reg) |-> $past(p4_adv && p4_done_reg))
        else $error("learned bias valid without a completed estimate");

    // A completing item leaves no estimate running behind it in the accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (p1_adv && done_c) |=> !busy_reg)
        else $error("estimate still running after its last sample");

endmodule

// ===== bench/six_axis_bias_estimate_and_removal_top_test.sv =====
`timescale 1ns / 1ps

module six_axis_bias_estimate_and_removal_top_test;
    import sabr_pkg::*;

    localparam int AVG_N       = AVG_COUNT_DEFAULT;
    localparam int LATENCY     = 4;
    localparam int STALL_LIMIT = 2000;

    localparam longint SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam longint SAMPLE_MIN = -(2 ** (SAMPLE_BITS - 1));
    localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Indexes 6 and 7 decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] OFFSET_REGS [NUM_CH] = '{
        REG_BIAS_FORCE_X, REG_BIAS_FORCE_Y, REG_BIAS_FORCE_Z,
        REG_BIAS_TORQUE_X, REG_BIAS_TORQUE_Y, REG_BIAS_TORQUE_Z
    };

    typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] wrench_t;

    typedef struct packed {
        logic                             estimating;
        logic                             done;
        logic [NUM_CH-1:0][COMP_BITS-1:0] comp;
    } comp_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]   idx;
        logic [SAMPLE_BITS-1:0] value;
    } offset_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SAMPLE_BITS-1:0] cfg_data;

    six_axis_bias_estimate_and_removal_top #(
        .AVG_COUNT (AVG_N)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the block state used to predict each compensated sample.
    longint cfg_offset [NUM_CH] = '{default: 0};
    longint est_sum    [NUM_CH] = '{default: 0};
    longint est_bias   [NUM_CH] = '{default: 0};
    int     est_count           = 0;
    bit     est_running         = 1'b0;
    bit     est_bias_valid      = 1'b0;

    comp_result_t  expected_results [$];
    offset_write_t offset_writes [$];

    string channel_name [NUM_CH] = '{
        "comp_force_x", "comp_force_y", "comp_force_z",
        "comp_torque_x", "comp_torque_y", "comp_torque_z"
    };

    int mismatches  = 0;
    int idle_cycles = 0;
    int tx_items    = 0;
    int rx_items    = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    comp_result_t got;
    comp_result_t want;

    // Predict one result and advance the shadow estimator by one sample.
    function automatic comp_result_t predict_compensated(input logic start, input wrench_t smp);
        comp_result_t r;
        sample_t      v;
        longint       diff;
        logic         finished;
        finished = 1'b0;
        if (start && !est_running)
        begin
            est_sum     = '{default: 0};
            est_count   = 0;
            est_running = 1'b1;
        end
        if (est_running)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                v = smp[i];
                est_sum[i] += v;
            end
            est_count = (est_count + 1) & 'h7f;
            if (est_count >= AVG_N)
            begin
                // Signed division truncates toward zero, as the hardware mean does.
                for (int i = 0; i < NUM_CH; i++)
                    est_bias[i] = est_sum[i] / AVG_N;
                est_bias_valid = 1'b1;
                est_running    = 1'b0;
                finished       = 1'b1;
            end
        end
        for (int i = 0; i < NUM_CH; i++)
        begin
            v    = smp[i];
            diff = longint'(v) - (est_bias_valid ? est_bias[i] : cfg_offset[i]);
            r.comp[i] = diff[COMP_BITS-1:0];
        end
        r.estimating = est_running;
        r.done       = finished;
        return r;
    endfunction

    function automatic wrench_t random_sample();
        wrench_t smp;
        for (int i = 0; i < NUM_CH; i++)
            smp[i] = SAMPLE_BITS'($urandom);
        return smp;
    endfunction

    // Sample scattered around a per-channel center, clamped to the sample range.
    function automatic wrench_t sample_near(input longint center [NUM_CH], input int spread);
        wrench_t smp;
        longint  v;
        for (int i = 0; i < NUM_CH; i++)
        begin
            v = center[i] - spread + longint'($urandom_range(0, 2 * spread));
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            else if (v < SAMPLE_MIN)
                v = SAMPLE_MIN;
            smp[i] = v[SAMPLE_BITS-1:0];
        end
        return smp;
    endfunction

    // Send one sample, honoring a random gap, and record its prediction on transfer.
    task automatic send_sample(input logic start, input wrench_t smp);
        int gap;
        if (tx_items % 40 == 0)
            tx_steady = ($urandom_range(0, 2) == 0);
        tx_items++;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_compensated(start, smp));
        @(negedge clk);
    endtask

    // Stop the stream and wait until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() > 0);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_BITS-1:0] value);
        offset_write_t w;
        w.idx   = idx;
        w.value = value;
        offset_writes.push_back(w);
    endtask

    task automatic queue_all_offsets(input logic [SAMPLE_BITS-1:0] value);
        for (int i = 0; i < NUM_CH; i++)
            queue_write(OFFSET_REGS[i], value);
    endtask

    // Apply queued register writes back to back once the block is idle.
    task automatic flush_offset_writes();
        offset_write_t w;
        sample_t       v;
        drain_results();
        while (offset_writes.size() > 0)
        begin
            w = offset_writes.pop_front();
            cfg_wr_en <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.value;
            @(posedge clk);
            // A mapped write also drops the learned bias.
            if (w.idx < NUM_CH)
            begin
                v = w.value;
                cfg_offset[w.idx] = v;
                est_bias_valid    = 1'b0;
            end
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One full estimate: start on the first sample, stray starts while busy, optional
    // start on the completing sample.
    task automatic run_estimate(input longint center [NUM_CH], input int spread,
                                input bit start_on_last);
        logic start;
        while (est_running)
            send_sample(1'b0, random_sample());
        for (int n = 0; n < AVG_N; n++)
        begin
            if (n == 0)
                start = 1'b1;
            else if (n == AVG_N - 1)
                start = start_on_last;
            else
                start = ($urandom_range(0, 15) == 0);
            send_sample(start, sample_near(center, spread));
        end
    endtask

    // Field extremes against zero, minimum, maximum and alternating offsets.
    task automatic test_extremes();
        send_sample(1'b0, '0);
        send_sample(1'b0, {NUM_CH{FULL_POS}});
        send_sample(1'b0, {NUM_CH{FULL_NEG}});
        send_sample(1'b0, '1);
        send_sample(1'b0, {NUM_CH{24'h555555}});
        send_sample(1'b0, {NUM_CH{24'hAAAAAA}});
        send_sample(1'b0, {FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG});

        queue_all_offsets(FULL_NEG);
        flush_offset_writes();
        send_sample(1'b0, {NUM_CH{FULL_POS}});
        send_sample(1'b0, {NUM_CH{FULL_NEG}});
        send_sample(1'b0, '0);

        queue_all_offsets(FULL_POS);
        flush_offset_writes();
        send_sample(1'b0, {NUM_CH{FULL_NEG}});
        send_sample(1'b0, {NUM_CH{FULL_POS}});
        send_sample(1'b0, '1);

        for (int i = 0; i < NUM_CH; i++)
            queue_write(OFFSET_REGS[i], (i % 2) ? FULL_NEG : FULL_POS);
        flush_offset_writes();
        send_sample(1'b0, {FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG});
        send_sample(1'b0, {FULL_NEG, FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS});

        queue_all_offsets('0);
        flush_offset_writes();
    endtask

    // Random offsets in every register; unmapped indexes must change nothing.
    task automatic test_offset_registers();
        for (int round = 0; round < 4; round++)
        begin
            for (int i = 0; i < NUM_CH; i++)
                queue_write(OFFSET_REGS[i], SAMPLE_BITS'($urandom));
            queue_write(REG_UNMAPPED_LO, SAMPLE_BITS'($urandom));
            queue_write(REG_UNMAPPED_HI, SAMPLE_BITS'($urandom));
            flush_offset_writes();
            repeat (6) send_sample(1'b0, random_sample());
        end
    endtask

    // Estimates over extreme, flat and noisy sample sets, each checked afterwards.
    task automatic test_estimation_runs();
        longint  center [NUM_CH];
        int      spread;
        sample_t c;
        for (int r = 0; r < 8; r++)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                c = SAMPLE_BITS'($urandom);
                center[i] = (r == 0) ? SAMPLE_MIN : (r == 1) ? SAMPLE_MAX : longint'(c);
            end
            case ($urandom_range(0, 3))
                0: spread = 3;
                1: spread = 200;
                2: spread = 50000;
                default: spread = 8388607;
            endcase
            if (r < 2)
                spread = 0;
            run_estimate(center, spread, r[0]);
            repeat (5) send_sample(1'b0, sample_near(center, spread));
        end
    endtask

    // Learned bias survives unmapped writes, yields to mapped ones, and a write in
    // the middle of an estimate does not stop it.
    task automatic test_bias_reload();
        longint  center [NUM_CH];
        sample_t c;
        for (int i = 0; i < NUM_CH; i++)
        begin
            c = SAMPLE_BITS'($urandom);
            center[i] = c;
        end
        run_estimate(center, 100, 1'b0);
        repeat (3) send_sample(1'b0, sample_near(center, 100));

        queue_write(REG_UNMAPPED_LO, SAMPLE_BITS'($urandom));
        queue_write(REG_UNMAPPED_HI, SAMPLE_BITS'($urandom));
        flush_offset_writes();
        repeat (4) send_sample(1'b0, sample_near(center, 100));

        queue_write(REG_BIAS_TORQUE_Y, SAMPLE_BITS'($urandom));
        flush_offset_writes();
        repeat (4) send_sample(1'b0, sample_near(center, 100));

        for (int n = 0; n < 40; n++)
            send_sample(n == 0, sample_near(center, 5000));
        queue_write(REG_BIAS_FORCE_X, SAMPLE_BITS'($urandom));
        flush_offset_writes();
        while (est_running)
            send_sample(1'b0, sample_near(center, 5000));
        repeat (4) send_sample(1'b0, sample_near(center, 5000));
    endtask

    // Free-running stream with sporadic starts and register writes between phases.
    task automatic test_random_stream();
        wrench_t smp;
        for (int n = 0; n < 500; n++)
        begin
            if (n % 100 == 99)
            begin
                repeat ($urandom_range(1, 3))
                    queue_write(CFG_IDX_W'($urandom), SAMPLE_BITS'($urandom));
                flush_offset_writes();
            end
            smp = random_sample();
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < NUM_CH; i++)
                    smp[i] = SAMPLE_BITS'($signed($urandom_range(0, 64)) - 32);
            send_sample($urandom_range(0, 39) == 0, smp);
        end
    endtask

    // Result side: random stall before each transfer, with stretches of none.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_items % 32 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            rx_items++;
            stall = rx_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.comp       = m_tdata[NUM_CH*COMP_BITS-1:0];
            got.estimating = m_tuser[USER_ESTIMATING];
            got.done       = m_tuser[USER_DONE];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result with nothing expected, data %h user %b",
                             m_tdata, m_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (got.comp[i] !== want.comp[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %s: expected %0d got %0d", channel_name[i],
                                     $signed(want.comp[i]), $signed(got.comp[i]));
                    end
                end
                if (got.estimating !== want.estimating)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch estimating: expected %b got %b",
                                 want.estimating, got.estimating);
                end
                if (got.done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch estimate_done: expected %b got %b",
                                 want.done, got.done);
                end
            end
        end
    end

    // Watchdog: too long without any transfer or register write ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_offset_registers();
        test_estimation_runs();
        test_bias_reload();
        test_random_stream();

        drain_results();
        repeat (LATENCY + 4) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
